FILE: rtl/fst_pkg.sv
// Shared types, constants and helper functions of the framed serial transmitter.
`timescale 1ns / 1ps

package fst_pkg;

    localparam int FIFO_DEPTH      = 32;
    localparam int SPACE_THRESHOLD = 16;
    localparam int PTR_W           = $clog2(FIFO_DEPTH);
    localparam int CNT_W           = $clog2(FIFO_DEPTH + 1);
    localparam int BYTE_W          = 8;
    localparam int FRAME_W         = 12;
    localparam int BITS_W          = 4;
    localparam int CMDQ_DEPTH      = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 1;

    localparam logic [FRAME_W-1:0] IDLE_FRAME = 12'hFFF;
    localparam logic [BITS_W-1:0]  BITS_8N1   = 4'd9;
    localparam logic [BITS_W-1:0]  BITS_8E2   = 4'd11;

    // Free slots >= threshold is the same as stored bytes <= depth - threshold.
    localparam bit SPACE_POSSIBLE = (SPACE_THRESHOLD <= FIFO_DEPTH);
    localparam int SPACE_MAX      = SPACE_POSSIBLE ? (FIFO_DEPTH - SPACE_THRESHOLD) : 0;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_MODE  = 1'b0,
        CFG_LINE_INVERT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] tx_byte;
        logic              hold;
    } t_req;

    typedef struct packed {
        logic line_level;
        logic write_accepted;
        logic has_space;
        logic busy_res;
    } t_res;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic              hold;
    } t_cmd;

    typedef struct packed {
        logic frame_mode;
        logic line_invert;
    } t_cfg;

    function automatic logic [FRAME_W-1:0] build_frame(input logic [BYTE_W-1:0] b,
                                                      input logic mode);
        logic [FRAME_W-1:0] f;
        if (mode) begin
            f = {2'b11, ^b, b, 1'b0};
        end else begin
            f = {3'b111, b, 1'b0};
        end
        return f;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + 1'b1;
        end
        return n;
    endfunction

endpackage

FILE: rtl/fst_if.sv
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps

interface fst_req_if import fst_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fst_res_if import fst_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/fst_front.sv
// Front end: accepts request items, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module fst_front import fst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fst_req_if.sink     req,
    output t_cmd        o_cmd,
    output logic        o_cmd_valid,
    input  logic        i_cmd_pop
);

    t_cmd       r_q [CMDQ_DEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd_in;

    assign req.ready   = (r_cnt != 2'(CMDQ_DEPTH));
    assign push        = req.valid && req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        cmd_in.op   = req.data.req_type ? OP_TICK : OP_WRITE;
        cmd_in.data = req.data.tx_byte;
        cmd_in.hold = req.data.hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
    end

endmodule

FILE: rtl/fst_back.sv
// Back end: byte FIFO, frame shifter and registered result output.
`timescale 1ns / 1ps

module fst_back import fst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_valid,
    output logic        o_cmd_pop,
    input  t_cfg        i_cfg,
    fst_res_if.source   res
);

    logic [BYTE_W-1:0]  r_mem [FIFO_DEPTH];
    logic [BYTE_W-1:0]  r_head;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FRAME_W-1:0] r_shift, n_shift;
    logic [BITS_W-1:0]  r_bits, n_bits;
    logic               r_sending, n_sending;
    logic               r_out_valid;
    t_res               r_res, n_res;

    logic               fire;
    logic               is_wr;
    logic               is_tick;
    logic               fifo_full;
    logic               fifo_empty;
    logic               wr_en;
    logic               can_go;
    logic [CNT_W-1:0]   n_count;

    assign fire       = i_cmd_valid && (!r_out_valid || res.ready);
    assign o_cmd_pop  = fire;
    assign is_wr      = fire && (i_cmd.op == OP_WRITE);
    assign is_tick    = fire && (i_cmd.op == OP_TICK);
    assign fifo_full  = (ptr_inc(r_wr_ptr) == r_rd_ptr);
    assign fifo_empty = (r_wr_ptr == r_rd_ptr);
    assign wr_en      = is_wr && !fifo_full;
    assign can_go     = !i_cmd.hold && !fifo_empty;

    always_comb begin
        n_wr_ptr  = wr_en ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_shift   = r_shift;
        n_bits    = r_bits;
        n_sending = r_sending;
        if (is_tick) begin
            priority if (r_sending && (r_bits != '0)) begin
                n_shift = {1'b1, r_shift[FRAME_W-1:1]};
                n_bits  = r_bits - 1'b1;
            end else if (!r_sending) begin
                // The leading idle bit goes out before the first frame.
                n_shift   = IDLE_FRAME;
                n_bits    = '0;
                n_sending = can_go;
            end else if (can_go) begin
                n_shift  = build_frame(r_head, i_cfg.frame_mode);
                n_bits   = i_cfg.frame_mode ? BITS_8E2 : BITS_8N1;
                n_rd_ptr = ptr_inc(r_rd_ptr);
            end else begin
                n_sending = 1'b0;
                n_shift   = IDLE_FRAME;
                n_bits    = '0;
            end
        end
    end

    always_comb begin
        if (n_wr_ptr >= n_rd_ptr) begin
            n_count = CNT_W'(n_wr_ptr) - CNT_W'(n_rd_ptr);
        end else begin
            n_count = CNT_W'(n_wr_ptr) + CNT_W'(FIFO_DEPTH) - CNT_W'(n_rd_ptr);
        end
        n_res.line_level     = n_shift[0] ^ i_cfg.line_invert;
        n_res.write_accepted = wr_en;
        n_res.has_space      = SPACE_POSSIBLE && (n_count <= CNT_W'(SPACE_MAX));
        n_res.busy_res       = n_sending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_shift     <= IDLE_FRAME;
            r_bits      <= '0;
            r_sending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_shift   <= n_shift;
            r_bits    <= n_bits;
            r_sending <= n_sending;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    // The head register always holds the byte at the read pointer; a write into
    // an empty FIFO lands at that address and is forwarded.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cmd.data;
        end
        if (wr_en && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_cmd.data;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    assign res.valid = r_out_valid;
    assign res.data  = r_res;

endmodule

FILE: rtl/framed_serial_transmitter.sv
// Top level of the framed serial transmitter: configuration registers and front/back ends.
//
// Request channel (i_req): each item is either a byte write (req_type 0) or one
// bit-time tick (req_type 1). Result channel (o_res): exactly one result item per
// request item, in order: line level, write accepted, FIFO space flag, busy.
// Bytes wait in a 32-entry FIFO that keeps one slot empty; each tick shifts the
// frame shifter by one bit (8N1 or 8E2 framing, LSB first, optional inversion).
// Configuration: i_cfg_we writes register i_cfg_idx (0 frame mode, 1 line
// invert); the user must see that it is written only while no item is in flight;
// the block does not enforce this. Throughput: one item per clock while the result
// channel is not stalled. A result becomes valid once its item has passed the
// command queue and the result register. The FIFO has a registered read of its head byte.
// Reset: the FIFO is emptied, the line goes idle (high before inversion), the
// configuration clears to 8N1 without inversion, and i_req.ready is high in the
// first cycle after reset.
// Receiver stall: the result register holds its item; the two-entry command queue
// keeps accepting until it fills, then i_req.ready drops.
`timescale 1ns / 1ps

module framed_serial_transmitter import fst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fst_req_if.sink               i_req,
    fst_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_MODE: begin
                    r_cfg.frame_mode <= i_cfg_data[0];
                end
                CFG_LINE_INVERT: begin
                    r_cfg.line_invert <= i_cfg_data[0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    fst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .req         (i_req),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    fst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (r_cfg),
        .res         (o_res)
    );

endmodule

FILE: rtl/fst_checker.sv
// Port-level checks of the framed serial transmitter and their bind to the top level.
`timescale 1ns / 1ps

module fst_port_checker import fst_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_res i_out_data
);

    // A stalled result item keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result item changed while stalled");

    // Reset leaves no result pending.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // The command queue is empty after reset, so requests are taken at once.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("request channel not ready after reset");

    // The command queue only fills while the result side is stalled.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> $past(i_out_valid && !i_out_ready))
        else $error("request channel stalled without a result stall");

endmodule

bind framed_serial_transmitter fst_port_checker u_fst_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
